@@ hdl/bpc_pkg.sv @@
// shared types and constants for the barometric pressure compensation block
package bpc_pkg;

    localparam int RAW_W  = 24;
    localparam int DT_W   = RAW_W + 1;
    localparam int CAL_W  = 16;
    localparam int IDX_W  = 3;
    localparam int TEMP_W = 19;
    localparam int PRES_W = 32;

    localparam logic signed [TEMP_W-1:0] TEMP_COLD  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_FROST = -19'sd1500;

    typedef enum logic [IDX_W-1:0] {
        REG_SENS_COEF      = 3'd0,
        REG_OFFSET_COEF    = 3'd1,
        REG_SENS_TEMPCO    = 3'd2,
        REG_OFFSET_TEMPCO  = 3'd3,
        REG_REF_TEMP       = 3'd4,
        REG_TEMP_SENS_COEF = 3'd5
    } bpc_reg_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] sens_coef;
        logic [CAL_W-1:0] offset_coef;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temperature;
        logic [CAL_W-1:0] temp_sens_coef;
    } bpc_cal_t;

    // one reading pair after the front end: raw pressure and temperature difference
    typedef struct packed {
        logic [RAW_W-1:0]        d1;
        logic signed [DT_W-1:0]  dt;
    } bpc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bpc_q_stat_t;

endpackage

@@ hdl/bpc_front.sv @@
// input side: accepts reading pairs and forms the temperature difference
module bpc_front (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bpc_pkg::RAW_W-1:0]         s_raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]         s_raw_temperature,
    input  logic [bpc_pkg::CAL_W-1:0]         ref_temperature,
    input  bpc_pkg::bpc_q_stat_t              q_stat,
    output logic                              push,
    output bpc_pkg::bpc_item_t                item
);
    import bpc_pkg::*;

    logic signed [DT_W-1:0] raw_t_ext;
    logic signed [DT_W-1:0] ref_t_ext;

    assign s_ready   = !q_stat.full;
    assign push      = s_valid && !q_stat.full;

    // dT = D2 - C5 * 256
    assign raw_t_ext = {1'b0, s_raw_temperature};
    assign ref_t_ext = {1'b0, ref_temperature, 8'b0};
    assign item.d1   = s_raw_pressure;
    assign item.dt   = raw_t_ext - ref_t_ext;

endmodule

@@ hdl/bpc_queue.sv @@
// short item queue between the front end and the arithmetic pipeline
module bpc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  bpc_pkg::bpc_item_t   push_item,
    input  logic                 pop,
    output bpc_pkg::bpc_item_t   head_item,
    output bpc_pkg::bpc_q_stat_t stat
);
    import bpc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bpc_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

@@ hdl/bpc_back.sv @@
// arithmetic pipeline: first-order terms, cold correction and final pressure
module bpc_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bpc_pkg::bpc_cal_t                      cal,
    input  logic                                   q_valid,
    input  bpc_pkg::bpc_item_t                     q_item,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bpc_pkg::TEMP_W-1:0]      m_comp_temp,
    output logic signed [bpc_pkg::PRES_W-1:0]      m_comp_pres
);
    import bpc_pkg::*;

    logic advance;

    // stage 2: products of dT
    logic                    s2_valid_reg;
    logic [RAW_W-1:0]        s2_d1_reg;
    logic signed [41:0]      s2_mt_reg, s2_mt_next;
    logic signed [41:0]      s2_mo_reg, s2_mo_next;
    logic signed [41:0]      s2_ms_reg, s2_ms_next;
    logic signed [49:0]      s2_dd_reg, s2_dd_next;

    // stage 3: first-order TEMP, OFF, SENS and T2
    logic                    s3_valid_reg;
    logic [RAW_W-1:0]        s3_d1_reg;
    logic signed [TEMP_W-1:0] s3_temp_reg, s3_temp_next;
    logic signed [35:0]      s3_off_reg, s3_off_next;
    logic signed [35:0]      s3_sens_reg, s3_sens_next;
    logic signed [TEMP_W-1:0] s3_t2_reg, s3_t2_next;
    logic signed [41:0]      mt_sh, mo_sh, ms_sh;
    logic signed [49:0]      dd_sh;
    logic signed [35:0]      off_base, sens_base;

    // stage 4: squares of the distances below the two thresholds
    logic                    s4_valid_reg;
    logic [RAW_W-1:0]        s4_d1_reg;
    logic signed [TEMP_W-1:0] s4_temp_reg;
    logic signed [35:0]      s4_off_reg;
    logic signed [35:0]      s4_sens_reg;
    logic signed [TEMP_W-1:0] s4_t2_reg;
    logic                    s4_cold_reg, s4_cold_next;
    logic                    s4_frost_reg, s4_frost_next;
    logic signed [39:0]      s4_aa_reg, s4_aa_next;
    logic signed [39:0]      s4_bb_reg, s4_bb_next;
    logic signed [19:0]      dist_a, dist_b;

    // stage 5: correction terms
    logic                    s5_valid_reg;
    logic [RAW_W-1:0]        s5_d1_reg;
    logic signed [TEMP_W-1:0] s5_temp_reg, s5_temp_next;
    logic signed [35:0]      s5_off_reg;
    logic signed [35:0]      s5_sens_reg;
    logic signed [41:0]      s5_off2_reg, s5_off2_next;
    logic signed [41:0]      s5_sens2_reg, s5_sens2_next;
    logic signed [41:0]      aa_x, bb_x, five_aa, seven_bb, eleven_bb;

    // stage 6: corrected OFF and SENS
    logic                    s6_valid_reg;
    logic [RAW_W-1:0]        s6_d1_reg;
    logic signed [TEMP_W-1:0] s6_temp_reg;
    logic signed [41:0]      s6_off_reg, s6_off_next;
    logic signed [41:0]      s6_sens_reg, s6_sens_next;

    // stage 7: D1 * SENS as two partial products split at bit 21
    logic                    s7_valid_reg;
    logic signed [TEMP_W-1:0] s7_temp_reg;
    logic signed [41:0]      s7_off_reg;
    logic [44:0]             s7_pl_reg, s7_pl_next;
    logic signed [45:0]      s7_ph_reg, s7_ph_next;

    // stage 8: floor(D1 * SENS / 2^21)
    logic                    s8_valid_reg;
    logic signed [TEMP_W-1:0] s8_temp_reg;
    logic signed [41:0]      s8_off_reg;
    logic signed [46:0]      s8_q_reg, s8_q_next;

    // output register
    logic                    out_valid_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic signed [PRES_W-1:0] out_pres_reg, out_pres_next;
    logic signed [47:0]      diff;

    assign advance = !out_valid_reg || m_ready;
    assign q_pop   = advance && q_valid;

    assign m_valid     = out_valid_reg;
    assign m_comp_temp = out_temp_reg;
    assign m_comp_pres = out_pres_reg;

    always_comb begin
        s2_mt_next = q_item.dt * $signed({1'b0, cal.temp_sens_coef});
        s2_mo_next = q_item.dt * $signed({1'b0, cal.offset_tempco});
        s2_ms_next = q_item.dt * $signed({1'b0, cal.sens_tempco});
        s2_dd_next = q_item.dt * q_item.dt;
    end

    always_comb begin
        mt_sh        = s2_mt_reg >>> 23;
        mo_sh        = s2_mo_reg >>> 7;
        ms_sh        = s2_ms_reg >>> 8;
        dd_sh        = s2_dd_reg >>> 31;
        off_base     = {4'b0, cal.offset_coef, 16'b0};
        sens_base    = {5'b0, cal.sens_coef, 15'b0};
        s3_temp_next = TEMP_COLD + $signed(mt_sh[TEMP_W-1:0]);
        s3_off_next  = off_base + $signed(mo_sh[35:0]);
        s3_sens_next = sens_base + $signed(ms_sh[35:0]);
        s3_t2_next   = $signed(dd_sh[TEMP_W-1:0]);
    end

    always_comb begin
        dist_a        = 20'(s3_temp_reg) - 20'(TEMP_COLD);
        dist_b        = 20'(s3_temp_reg) - 20'(TEMP_FROST);
        s4_aa_next    = dist_a * dist_a;
        s4_bb_next    = dist_b * dist_b;
        s4_cold_next  = s3_temp_reg < TEMP_COLD;
        s4_frost_next = s3_temp_reg < TEMP_FROST;
    end

    always_comb begin
        aa_x      = 42'(s4_aa_reg);
        bb_x      = 42'(s4_bb_reg);
        five_aa   = (aa_x <<< 2) + aa_x;
        seven_bb  = (bb_x <<< 3) - bb_x;
        eleven_bb = (bb_x <<< 3) + (bb_x <<< 1) + bb_x;
        s5_off2_next  = '0;
        s5_sens2_next = '0;
        s5_temp_next  = s4_temp_reg;
        if (s4_cold_reg) begin
            s5_temp_next  = s4_temp_reg - s4_t2_reg;
            s5_off2_next  = five_aa >>> 1;
            s5_sens2_next = five_aa >>> 2;
            if (s4_frost_reg) begin
                s5_off2_next  = (five_aa >>> 1) + seven_bb;
                s5_sens2_next = (five_aa >>> 2) + (eleven_bb >>> 1);
            end
        end
    end

    always_comb begin
        s6_off_next  = 42'(s5_off_reg) - s5_off2_reg;
        s6_sens_next = 42'(s5_sens_reg) - s5_sens2_reg;
    end

    always_comb begin
        s7_pl_next = s6_d1_reg * s6_sens_reg[20:0];
        s7_ph_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[41:21]);
    end

    // low partial product is non-negative, so its floor is a plain bit-select
    always_comb begin
        s8_q_next = 47'(s7_ph_reg) + $signed({23'b0, s7_pl_reg[44:21]});
    end

    always_comb begin
        diff          = 48'(s8_q_reg) - 48'(s8_off_reg);
        out_pres_next = $signed(diff[46:15]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg  <= q_valid;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            out_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_d1_reg    <= q_item.d1;
            s2_mt_reg    <= s2_mt_next;
            s2_mo_reg    <= s2_mo_next;
            s2_ms_reg    <= s2_ms_next;
            s2_dd_reg    <= s2_dd_next;

            s3_d1_reg    <= s2_d1_reg;
            s3_temp_reg  <= s3_temp_next;
            s3_off_reg   <= s3_off_next;
            s3_sens_reg  <= s3_sens_next;
            s3_t2_reg    <= s3_t2_next;

            s4_d1_reg    <= s3_d1_reg;
            s4_temp_reg  <= s3_temp_reg;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_t2_reg    <= s3_t2_reg;
            s4_cold_reg  <= s4_cold_next;
            s4_frost_reg <= s4_frost_next;
            s4_aa_reg    <= s4_aa_next;
            s4_bb_reg    <= s4_bb_next;

            s5_d1_reg    <= s4_d1_reg;
            s5_temp_reg  <= s5_temp_next;
            s5_off_reg   <= s4_off_reg;
            s5_sens_reg  <= s4_sens_reg;
            s5_off2_reg  <= s5_off2_next;
            s5_sens2_reg <= s5_sens2_next;

            s6_d1_reg    <= s5_d1_reg;
            s6_temp_reg  <= s5_temp_reg;
            s6_off_reg   <= s6_off_next;
            s6_sens_reg  <= s6_sens_next;

            s7_temp_reg  <= s6_temp_reg;
            s7_off_reg   <= s6_off_reg;
            s7_pl_reg    <= s7_pl_next;
            s7_ph_reg    <= s7_ph_next;

            s8_temp_reg  <= s7_temp_reg;
            s8_off_reg   <= s7_off_reg;
            s8_q_reg     <= s8_q_next;

            out_temp_reg <= s8_temp_reg;
            out_pres_reg <= out_pres_next;
        end
    end

`ifndef SYNTHESIS
    a_frost_is_cold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_valid_reg && s4_frost_reg) |-> s4_cold_reg)
        else $error("frost correction without cold correction");

    a_t2_non_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> !s3_t2_reg[TEMP_W-1])
        else $error("negative second-order temperature term");

    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s8_valid_reg) |=> out_valid_reg)
        else $error("item lost between last stage and output register");
`endif

endmodule

@@ hdl/barometric_pressure_compensation.sv @@
// top level: calibration registers, front end, item queue and arithmetic pipeline
// an accepted item is written into the queue, then passes the pipeline stages and the output register
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined multiplier chain
// the queue holds up to QUEUE_DEPTH items so the input keeps flowing during short output stalls
// reset: synchronous active-low aresetn clears the six calibration words to zero,
// the queue pointers and every pipeline valid flag; no clearing pass is needed
module barometric_pressure_compensation #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [bpc_pkg::IDX_W-1:0]              cfg_index,
    input  logic [bpc_pkg::CAL_W-1:0]              cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [bpc_pkg::RAW_W-1:0]              s_raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]              s_raw_temperature,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bpc_pkg::TEMP_W-1:0]      m_comp_temp,
    output logic signed [bpc_pkg::PRES_W-1:0]      m_comp_pres
);
    import bpc_pkg::*;

    bpc_cal_t    cal_reg, cal_next;
    bpc_q_stat_t q_stat;
    bpc_item_t   push_item, head_item;
    logic        push, pop;

    always_comb begin
        cal_next = cal_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SENS_COEF:      cal_next.sens_coef       = cfg_data;
                REG_OFFSET_COEF:    cal_next.offset_coef     = cfg_data;
                REG_SENS_TEMPCO:    cal_next.sens_tempco     = cfg_data;
                REG_OFFSET_TEMPCO:  cal_next.offset_tempco   = cfg_data;
                REG_REF_TEMP:       cal_next.ref_temperature = cfg_data;
                REG_TEMP_SENS_COEF: cal_next.temp_sens_coef  = cfg_data;
                default:            cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    bpc_front u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_pressure    (s_raw_pressure),
        .s_raw_temperature (s_raw_temperature),
        .ref_temperature   (cal_reg.ref_temperature),
        .q_stat            (q_stat),
        .push              (push),
        .item              (push_item)
    );

    bpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    bpc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cal         (cal_reg),
        .q_valid     (!q_stat.empty),
        .q_item      (head_item),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_comp_temp (m_comp_temp),
        .m_comp_pres (m_comp_pres)
    );

endmodule

@@ sim/barometric_pressure_compensation_tb.sv @@
// testbench for the barometric pressure compensation block: random and directed readings
module barometric_pressure_compensation_tb;
    import bpc_pkg::*;

    typedef struct packed {
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
    } raw_pair_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
    } reading_t;

    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CAL_W-1:0]          cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [RAW_W-1:0]          s_raw_pressure = '0;
    logic [RAW_W-1:0]          s_raw_temperature = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [TEMP_W-1:0]  m_comp_temp;
    logic signed [PRES_W-1:0]  m_comp_pres;

    bpc_cal_t  cal_words = '0;
    raw_pair_t raw_backlog[$];
    reading_t  expected_readings[$];
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        fault_count = 0;

    always #5 aclk = ~aclk;

    barometric_pressure_compensation DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_pressure    (s_raw_pressure),
        .s_raw_temperature (s_raw_temperature),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_comp_temp       (m_comp_temp),
        .m_comp_pres       (m_comp_pres)
    );

    // second-order compensation with floor shifts on 64-bit signed values
    function automatic reading_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        longint   dt, t, off, sens, a, b, t2, off2, sens2, p;
        reading_t r;
        dt   = longint'(d2) - longint'(cal_words.ref_temperature) * 256;
        t    = longint'(TEMP_COLD) + ((dt * longint'(cal_words.temp_sens_coef)) >>> 23);
        off  = longint'(cal_words.offset_coef) * 65536
             + ((longint'(cal_words.offset_tempco) * dt) >>> 7);
        sens = longint'(cal_words.sens_coef) * 32768
             + ((longint'(cal_words.sens_tempco) * dt) >>> 8);
        if (t < longint'(TEMP_COLD)) begin
            a     = t - longint'(TEMP_COLD);
            t2    = (dt * dt) >>> 31;
            off2  = (5 * a * a) >>> 1;
            sens2 = (5 * a * a) >>> 2;
            // frost terms use the first-order temperature as well
            if (t < longint'(TEMP_FROST)) begin
                b      = t - longint'(TEMP_FROST);
                off2  += 7 * b * b;
                sens2 += (11 * b * b) >>> 1;
            end
            t    -= t2;
            off  -= off2;
            sens -= sens2;
        end
        p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
        r.temp = t[TEMP_W-1:0];
        r.pres = p[PRES_W-1:0];
        return r;
    endfunction

    function automatic logic [RAW_W-1:0] raw_value();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) return '0;
        if (pick == 1) return RAW_MAX;
        return RAW_W'($urandom);
    endfunction

    task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SENS_COEF:      cal_words.sens_coef = val;
            REG_OFFSET_COEF:    cal_words.offset_coef = val;
            REG_SENS_TEMPCO:    cal_words.sens_tempco = val;
            REG_OFFSET_TEMPCO:  cal_words.offset_tempco = val;
            REG_REF_TEMP:       cal_words.ref_temperature = val;
            REG_TEMP_SENS_COEF: cal_words.temp_sens_coef = val;
            default: ;
        endcase
    endtask

    task automatic load_cal(input bpc_cal_t c);
        write_cal(REG_SENS_COEF, c.sens_coef);
        write_cal(REG_OFFSET_COEF, c.offset_coef);
        write_cal(REG_SENS_TEMPCO, c.sens_tempco);
        write_cal(REG_OFFSET_TEMPCO, c.offset_tempco);
        write_cal(REG_REF_TEMP, c.ref_temperature);
        write_cal(REG_TEMP_SENS_COEF, c.temp_sens_coef);
        // unused indexes must leave the calibration alone
        for (int i = REG_TEMP_SENS_COEF + 1; i < 2 ** IDX_W; i++) begin
            write_cal(i[IDX_W-1:0], CAL_W'($urandom));
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (raw_backlog.size() != 0 || expected_readings.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
    endtask

    // readings around the cold and frost thresholds for the current calibration
    task automatic queue_directed();
        longint    base, frost_dt, d2;
        raw_pair_t pr;
        base     = longint'(cal_words.ref_temperature) * 256;
        frost_dt = -((longint'(TEMP_COLD) - longint'(TEMP_FROST)) * (longint'(1) << 23))
                 / longint'(cal_words.temp_sens_coef);
        raw_backlog.push_back('{d1: '0, d2: '0});
        raw_backlog.push_back('{d1: RAW_MAX, d2: RAW_MAX});
        raw_backlog.push_back('{d1: '0, d2: RAW_MAX});
        raw_backlog.push_back('{d1: RAW_MAX, d2: '0});
        for (int k = -1; k <= 1; k++) begin
            d2 = base + k;
            pr.d1 = RAW_MAX;
            pr.d2 = d2[RAW_W-1:0];
            raw_backlog.push_back(pr);
        end
        for (int k = -2; k <= 1; k++) begin
            d2 = base + frost_dt + k;
            pr.d1 = 24'h800000;
            pr.d2 = d2[RAW_W-1:0];
            raw_backlog.push_back(pr);
        end
        pr.d1 = 24'h555555;
        pr.d2 = 24'haaaaaa;
        raw_backlog.push_back(pr);
        pr.d1 = 24'haaaaaa;
        pr.d2 = 24'h555555;
        raw_backlog.push_back(pr);
    endtask

    // driver
    always @(posedge aclk) begin : driver
        raw_pair_t next_pair;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_readings.push_back(compensate(s_raw_pressure, s_raw_temperature));
            end
            if (raw_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
                next_pair = raw_backlog.pop_front();
                s_valid           <= 1'b1;
                s_raw_pressure    <= next_pair.d1;
                s_raw_temperature <= next_pair.d2;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        reading_t want;
        m_ready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected item: comp_temp %0d comp_pres %0d",
                       m_comp_temp, m_comp_pres);
                fault_count++;
            end else begin
                want = expected_readings.pop_front();
                if (m_comp_temp !== want.temp) begin
                    $error("comp_temp expected %0d actual %0d",
                           want.temp, m_comp_temp);
                    fault_count++;
                end
                if (m_comp_pres !== want.pres) begin
                    $error("comp_pres expected %0d actual %0d",
                           want.pres, m_comp_pres);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        bpc_cal_t  c;
        raw_pair_t pr;
        int        n_items;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 78; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 78; end
                default: begin gap_pct = 24; stall_pct = 24; end
            endcase
            n_items = (phase == 0) ? 100 : 270;
            case (phase)
                0: ; // calibration straight out of reset
                1: begin
                    c.sens_coef       = 16'd40127;
                    c.offset_coef     = 16'd36924;
                    c.sens_tempco     = 16'd23317;
                    c.offset_tempco   = 16'd23282;
                    c.ref_temperature = 16'd33464;
                    c.temp_sens_coef  = 16'd28312;
                    load_cal(c);
                    queue_directed();
                end
                2: load_cal('1);
                3: load_cal('0);
                default: begin
                    c = {CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom),
                         CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom)};
                    load_cal(c);
                end
            endcase
            for (int i = 0; i < n_items; i++) begin
                pr.d1 = raw_value();
                pr.d2 = raw_value();
                raw_backlog.push_back(pr);
            end
        end
        wait_idle();
        if (fault_count == 0 && expected_readings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bpc_pkg.sv
hdl/bpc_front.sv
hdl/bpc_queue.sv
hdl/bpc_back.sv
hdl/barometric_pressure_compensation.sv
sim/barometric_pressure_compensation_tb.sv
